### design/gaussian_blur_replicate_border_assert.svh
// assertion macros for the blur block
`ifndef GAUSSIAN_BLUR_REPLICATE_BORDER_ASSERT_SVH
`define GAUSSIAN_BLUR_REPLICATE_BORDER_ASSERT_SVH
// implication checked every cycle out of reset
`define GBR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define GBR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### design/gbr_pkg.sv
// ----------------------------------------------------------------------------
// gbr_pkg
// shared constants and kernel coefficient function for the blur block
// ----------------------------------------------------------------------------
package gbr_pkg;
  localparam int KSIZE_DEF = 5;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int DIM_W = 11;
  localparam int PIX_W = 8;
  localparam int COEF_W = 24;
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;
  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // round(exp(k/2)), k clamped to 0..32
  function automatic logic [COEF_W-1:0] exp_half(input int k);
    logic [COEF_W-1:0] v;
    v = '0;
    case ((k < 0) ? 0 : ((k > 32) ? 32 : k))
      0: v = 24'd1;        1: v = 24'd2;        2: v = 24'd3;
      3: v = 24'd4;        4: v = 24'd7;        5: v = 24'd12;
      6: v = 24'd20;       7: v = 24'd33;       8: v = 24'd55;
      9: v = 24'd90;       10: v = 24'd148;     11: v = 24'd245;
      12: v = 24'd403;     13: v = 24'd665;     14: v = 24'd1097;
      15: v = 24'd1808;    16: v = 24'd2981;    17: v = 24'd4915;
      18: v = 24'd8103;    19: v = 24'd13360;   20: v = 24'd22026;
      21: v = 24'd36316;   22: v = 24'd59874;   23: v = 24'd98716;
      24: v = 24'd162755;  25: v = 24'd268337;  26: v = 24'd442413;
      27: v = 24'd729416;  28: v = 24'd1202604; 29: v = 24'd1982759;
      30: v = 24'd3269017; 31: v = 24'd5389698; 32: v = 24'd8886111;
      default: v = 24'd1;
    endcase
    return v;
  endfunction

  function automatic logic [COEF_W-1:0] coef(input int half, input int dx, input int dy);
    return exp_half(2 * half * half - dx * dx - dy * dy);
  endfunction

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             frame_end;
  } res_t;
endpackage

### design/gbr_stream_if.sv
// ----------------------------------------------------------------------------
// gbr_stream_if
// valid/ready channel interfaces for the blur block
// ----------------------------------------------------------------------------
interface gbr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] pixel_in;
  modport source (output valid, command, pixel_in, input ready);
  modport sink (input valid, command, pixel_in, output ready);
endinterface

interface gbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       row_end;
  logic       frame_end;
  modport source (output valid, pixel_out, row_end, frame_end, input ready);
  modport sink (input valid, pixel_out, row_end, frame_end, output ready);
endinterface

interface gbr_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/gbr_div.sv
// ----------------------------------------------------------------------------
// gbr_div
// divider by a constant, radix-4 compare and subtract, two quotient bits per
// cycle; the numerator must be below 2**Q_W * DEN
// ----------------------------------------------------------------------------
module gbr_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 32,
  parameter int Q_W = 8,
  parameter logic [DEN_W-1:0] DEN = DEN_W'(1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  output logic             done,
  output logic [Q_W-1:0]   quo
);
  localparam int STEPS = Q_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int R_W = DEN_W + 2;
  localparam logic [R_W-1:0] D1 = R_W'(DEN);
  localparam logic [R_W-1:0] D2 = R_W'({DEN, 1'b0});
  localparam logic [R_W-1:0] D3 = D1 + D2;
  logic [DEN_W-1:0] rem;
  logic [Q_W-1:0]   low;
  logic [Q_W-1:0]   q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [R_W-1:0]   trial;

  // upper part of the numerator is already below DEN
  assign trial = {rem, low[Q_W-1:Q_W-2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1)) && !start;
      if (start) begin
        busy <= 1'b1;
        rem <= DEN_W'(num[NUM_W-1:Q_W]);
        low <= num[Q_W-1:0];
        q <= '0;
        cnt <= CNT_W'(STEPS);
      end else if (busy) begin
        low <= {low[Q_W-3:0], 2'b00};
        if (trial >= D3) begin
          rem <= DEN_W'(trial - D3);
          q <= {q[Q_W-3:0], 2'd3};
        end else if (trial >= D2) begin
          rem <= DEN_W'(trial - D2);
          q <= {q[Q_W-3:0], 2'd2};
        end else if (trial >= D1) begin
          rem <= DEN_W'(trial - D1);
          q <= {q[Q_W-3:0], 2'd1};
        end else begin
          rem <= DEN_W'(trial);
          q <= {q[Q_W-3:0], 2'd0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) busy <= 1'b0;
      end
    end
  end
  assign quo = q;
endmodule

### design/gaussian_blur_replicate_border.sv
// ----------------------------------------------------------------------------
// gaussian_blur_replicate_border
// streaming gaussian blur of one byte plane with clamp-to-edge borders
// ----------------------------------------------------------------------------
// in: requests carry command (pixel or drain) and pixel_in, raster order.
// out: blurred pixel_out with row_end / frame_end markers, raster order.
// cfg: index 0 = image_width, 1 = image_height; a write restarts the frame.
// pixels go into a line ring of SPAN rows held in one synchronous ram.
// an output is produced once its clamped window has arrived; its SPAN*SPAN
// taps are read one per cycle from the ram and accumulated with a single
// multiplier, then divided by the constant kernel sum with a radix-4
// compare and subtract (four steps for the 8-bit quotient).
// each request releases at most KSIZE outputs and the input is stalled
// while they are computed. a stalled receiver holds the output register;
// the next result then waits and the block waits with it.
// reset clears positions and control; ram contents are not cleared (an
// entry is always written before it is read).
// ----------------------------------------------------------------------------
`include "gaussian_blur_replicate_border_assert.svh"
module gaussian_blur_replicate_border #(
  parameter int KSIZE = gbr_pkg::KSIZE_DEF,
  parameter int MAX_WIDTH = gbr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gbr_pkg::MAX_HEIGHT_DEF
) (
  input logic clk,
  input logic rst,
  gbr_in_if.sink   in_ch,
  gbr_out_if.source out_ch,
  gbr_cfg_if.sink  cfg
);
  localparam int HALF = KSIZE / 2;
  localparam int SPAN = 2 * HALF + 1;
  localparam int TAPS = SPAN * SPAN;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int SW = $clog2(SPAN);
  localparam int AW = $clog2(SPAN * MAX_WIDTH);
  localparam int TW = $clog2(TAPS + 1);
  localparam int NW = $clog2(KSIZE + 1);
  localparam int ACC_W = gbr_pkg::COEF_W + gbr_pkg::PIX_W + 6;
  localparam int NUM_W = ACC_W + 1;
  localparam int DEN_W = gbr_pkg::COEF_W + 8;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_CHECK = 6'b000010, S_READ = 6'b000100,
    S_DIV  = 6'b001000, S_WAITD = 6'b010000, S_EMIT = 6'b100000
  } state_t;

  function automatic logic [DEN_W-1:0] ksum();
    logic [DEN_W-1:0] s;
    s = '0;
    for (int y = -HALF; y <= HALF; y++)
      for (int x = -HALF; x <= HALF; x++)
        s = s + DEN_W'(gbr_pkg::coef(HALF, x, y));
    return s;
  endfunction
  localparam logic [DEN_W-1:0] KSUM = ksum();

  logic [gbr_pkg::COEF_W-1:0] coef_tab [TAPS];
  always_comb begin
    for (int t = 0; t < TAPS; t++)
      coef_tab[t] = gbr_pkg::coef(HALF, (t % SPAN) - HALF, (t / SPAN) - HALF);
  end

  state_t state;
  logic [CW:0] width;
  logic [RW:0] height;
  logic [CW-1:0] in_col, out_col;
  logic [RW-1:0] in_row, out_row;
  logic [SW-1:0] in_slot, out_slot;
  logic frame_in;
  logic [NW-1:0] emitted;
  logic [TW-1:0] tap;
  logic [SW-1:0] tx, ty;
  logic [ACC_W-1:0] acc;
  logic rd_valid;
  logic [SW-1:0] rd_tx, rd_ty;
  logic [gbr_pkg::PIX_W-1:0] mem [SPAN * MAX_WIDTH];
  logic [gbr_pkg::PIX_W-1:0] rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;
  logic div_start, div_done;
  logic [7:0] quo;
  gbr_pkg::res_t res;
  logic out_valid;

  logic [CW:0] wlast;
  logic [RW:0] hlast;
  assign wlast = width - 1'b1;
  assign hlast = height - 1'b1;

  // availability of output (out_row, out_col)
  logic [RW+1:0] need_r;
  logic [CW+1:0] need_c;
  logic avail;
  always_comb begin
    need_r = (RW + 2)'(out_row) + (RW + 2)'(HALF);
    if (need_r > (RW + 2)'(hlast)) need_r = (RW + 2)'(hlast);
    need_c = (CW + 2)'(out_col) + (CW + 2)'(HALF);
    if (need_c > (CW + 2)'(wlast)) need_c = (CW + 2)'(wlast);
    avail = frame_in || ((RW + 2)'(in_row) > need_r) ||
            (((RW + 2)'(in_row) == need_r) && ((CW + 2)'(in_col) > need_c));
  end

  // clamped tap coordinates
  logic signed [RW+2:0] rr, dr;
  logic signed [CW+2:0] cc;
  logic signed [SW+1:0] sl;
  logic [CW-1:0] rcol;
  logic [SW-1:0] rslot;
  always_comb begin
    rr = $signed((RW + 3)'(out_row)) + $signed((RW + 3)'(ty)) - (RW + 3)'(HALF);
    if (rr < 0) rr = '0;
    if (rr > $signed((RW + 3)'(hlast))) rr = (RW + 3)'(hlast);
    cc = $signed((CW + 3)'(out_col)) + $signed((CW + 3)'(tx)) - (CW + 3)'(HALF);
    if (cc < 0) cc = '0;
    if (cc > $signed((CW + 3)'(wlast))) cc = (CW + 3)'(wlast);
    rcol = cc[CW-1:0];
    // ring slot of the tap row, offset from the slot of out_row
    dr = rr - $signed((RW + 3)'(out_row));
    sl = $signed((SW + 2)'(out_slot)) + (SW + 2)'(dr);
    if (sl < 0) sl = sl + $signed((SW + 2)'(SPAN));
    else if (sl >= $signed((SW + 2)'(SPAN))) sl = sl - $signed((SW + 2)'(SPAN));
    rslot = sl[SW-1:0];
  end
  assign rd_addr = AW'(rslot) * AW'(MAX_WIDTH) + AW'(rcol);
  assign wr_addr = AW'(in_slot) * AW'(MAX_WIDTH) + AW'(in_col);

  logic in_acc, cfg_acc, out_acc;
  assign in_ch.ready = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready = (state == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg.valid && cfg.ready;
  assign out_acc = out_valid && out_ch.ready;
  assign wr_en = in_acc && (in_ch.command == gbr_pkg::CMD_PIXEL);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_ch.pixel_in;
    rd_data <= mem[rd_addr];
  end

  logic [10:0] dimv;
  always_comb begin
    dimv = cfg.data;
    if (dimv == '0) dimv = 11'd1;
  end

  logic restart_pix;
  assign restart_pix = wr_en && frame_in;

  always_ff @(posedge clk) begin
    div_start <= !rst && (state == S_DIV);
    if (rst) begin
      state <= S_IDLE;
      width <= (CW + 1)'(MAX_WIDTH);
      height <= (RW + 1)'(MAX_HEIGHT);
      in_col <= '0; in_row <= '0; in_slot <= '0;
      out_col <= '0; out_row <= '0; out_slot <= '0; frame_in <= 1'b0;
      out_valid <= 1'b0; rd_valid <= 1'b0;
    end else begin
      if (out_acc) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_acc) begin
            if (cfg.index == gbr_pkg::REG_WIDTH)
              width <= (32'(dimv) > MAX_WIDTH) ? (CW + 1)'(MAX_WIDTH)
                                               : (CW + 1)'(dimv);
            else
              height <= (32'(dimv) > MAX_HEIGHT) ? (RW + 1)'(MAX_HEIGHT)
                                                 : (RW + 1)'(dimv);
            in_col <= '0; in_row <= '0; in_slot <= '0;
            out_col <= '0; out_row <= '0; out_slot <= '0; frame_in <= 1'b0;
          end else if (in_acc) begin
            emitted <= '0;
            state <= S_CHECK;
            if (wr_en) begin
              // a pixel after a finished frame starts a new one at (0, 0)
              if (restart_pix) begin
                out_col <= '0; out_row <= '0; out_slot <= '0;
              end
              if ((CW + 1)'(in_col) == wlast) begin
                in_col <= '0;
                if ((RW + 1)'(in_row) == hlast) begin
                  in_row <= '0; in_slot <= '0; frame_in <= 1'b1;
                end else begin
                  in_row <= in_row + 1'b1;
                  in_slot <= (in_slot == SW'(SPAN - 1)) ? '0 : in_slot + 1'b1;
                  if (restart_pix) frame_in <= 1'b0;
                end
              end else begin
                in_col <= in_col + 1'b1;
                if (restart_pix) frame_in <= 1'b0;
              end
            end
          end
        end
        S_CHECK: begin
          if (emitted == NW'(KSIZE) || !avail) begin
            state <= S_IDLE;
          end else begin
            tap <= '0; tx <= '0; ty <= '0; acc <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          // address presented this cycle, data next cycle
          rd_valid <= (tap != TW'(TAPS));
          rd_tx <= tx; rd_ty <= ty;
          if (rd_valid)
            acc <= acc + ACC_W'(coef_tab[TW'(rd_ty) * TW'(SPAN) + TW'(rd_tx)]) *
                         ACC_W'(rd_data);
          if (tap != TW'(TAPS)) begin
            tap <= tap + 1'b1;
            if (tx == SW'(SPAN - 1)) begin
              tx <= '0; ty <= ty + 1'b1;
            end else tx <= tx + 1'b1;
          end else if (!rd_valid) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          state <= S_WAITD;
        end
        S_WAITD: begin
          if (div_done && !out_valid) begin
            res.pixel_out <= quo;
            res.row_end <= ((CW + 1)'(out_col) == wlast);
            res.frame_end <= ((CW + 1)'(out_col) == wlast) &&
                             ((RW + 1)'(out_row) == hlast);
            out_valid <= 1'b1;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          emitted <= emitted + 1'b1;
          if (res.frame_end) begin
            out_col <= '0; out_row <= '0; out_slot <= '0; frame_in <= 1'b0;
            in_col <= '0; in_row <= '0; in_slot <= '0;
            state <= S_IDLE;
          end else begin
            if (res.row_end) begin
              out_col <= '0; out_row <= out_row + 1'b1;
              out_slot <= (out_slot == SW'(SPAN - 1)) ? '0 : out_slot + 1'b1;
            end else out_col <= out_col + 1'b1;
            state <= S_CHECK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the divider done pulse is held until the output register frees
  logic div_pulse;
  logic div_hold;
  logic [NUM_W-1:0] num;
  assign num = {acc, 1'b0} + NUM_W'(KSUM);
  gbr_div #(
    .NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(8), .DEN({KSUM[DEN_W-2:0], 1'b0})
  ) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num),
    .done(div_pulse), .quo(quo)
  );
  always_ff @(posedge clk) begin
    if (rst) div_hold <= 1'b0;
    else if (state == S_WAITD && div_done && !out_valid) div_hold <= 1'b0;
    else if (div_pulse) div_hold <= 1'b1;
  end
  assign div_done = div_pulse || div_hold;

  assign out_ch.valid = out_valid;
  assign out_ch.pixel_out = res.pixel_out;
  assign out_ch.row_end = res.row_end;
  assign out_ch.frame_end = res.frame_end;

  `GBR_ASSERT_IMP(a_no_in_when_busy, state != S_IDLE, !in_ch.ready)
  `GBR_ASSERT_IMP(a_frame_end_row_end, out_valid && res.frame_end, res.row_end)
  `GBR_ASSERT_NEXT(a_emit_sets_valid, state == S_WAITD && div_done && !out_valid, out_valid)
  `GBR_ASSERT_IMP(a_burst_limit, state == S_READ, emitted < NW'(KSIZE))
endmodule
